/* rtl/core/mfs_pkg.sv */
package mfs_pkg;

  // Parser geometry
  localparam int unsigned HEX_DIGITS_DEF = 6;
  localparam int unsigned FIELD_COUNT    = 5;
  localparam int unsigned POS_W          = 7;
  localparam logic [POS_W-1:0] POS_MAX   = 7'd127;
  localparam int unsigned FIELD_START [FIELD_COUNT] = '{7, 19, 31, 43, 55};

  // Field order within a frame
  localparam int unsigned F_VOLT  = 0;
  localparam int unsigned F_CUR   = 1;
  localparam int unsigned F_REAL  = 2;
  localparam int unsigned F_PF    = 3;
  localparam int unsigned F_REACT = 4;

  // Widths of the result fields
  localparam int unsigned VOLT_W  = 34;
  localparam int unsigned CUR_W   = 30;
  localparam int unsigned REAL_W  = 39;
  localparam int unsigned PF_W    = 25;
  localparam int unsigned REACT_W = 29;

  // Quotient widths out of the constant dividers
  localparam int unsigned VOLT_Q_W  = 33;
  localparam int unsigned CUR_Q_W   = 29;
  localparam int unsigned REAL_Q_W  = 39;
  localparam int unsigned PF_Q_W    = 24;
  localparam int unsigned REACT_Q_W = 29;

  // Raw value offsets and thresholds, compared in a common width
  localparam int unsigned EXT_W      = 25;
  localparam int unsigned CUR_KNEE   = 3512;
  localparam int unsigned CUR_BIAS   = 275;
  localparam int unsigned REAL_BIAS  = 1000;
  localparam int unsigned REACT_BIAS = 89;

  // Each value is floor((y * P + B) / D), y being the biased raw value
  localparam int unsigned VOLT_P  = 6029312;   // 23 * 2^18
  localparam int unsigned VOLT_D  = 15625;
  localparam int unsigned CUR_P   = 2097152;   // 2^21
  localparam int unsigned CUR_D   = 78125;
  localparam int unsigned REAL_P  = 14680064;  // 7 * 2^21
  localparam int unsigned REAL_D  = 625;
  localparam int unsigned PF_P    = 1572864;   // 3 * 2^19
  localparam int unsigned PF_B    = 156250;
  localparam int unsigned PF_D    = 1953125;
  localparam int unsigned REACT_P = 2359296;   // 9 * 2^18
  localparam int unsigned REACT_B = 262144;    // 2^18
  localparam int unsigned REACT_D = 78125;

  // Constant terms removed after the divide
  localparam logic [VOLT_W-1:0] VOLT_OFS = 34'd33554432;
  localparam logic [PF_W-1:0]   PF_OFS   = 25'd2013266;

  typedef struct packed {
    logic mul;  // load the partial products
    logic sum;  // load the quotient
  } mfs_adv_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } mfs_hex_t;

  function automatic mfs_hex_t hex_decode(input logic [7:0] c);
    mfs_hex_t h;
    h.ok  = 1'b1;
    h.val = '0;
    case (c) inside
      [8'h30:8'h39]: h.val = 4'(c - 8'h30);
      [8'h41:8'h46]: h.val = 4'(c - 8'h37);
      [8'h61:8'h66]: h.val = 4'(c - 8'h57);
      default:       h.ok  = 1'b0;
    endcase
    return h;
  endfunction

endpackage

/* rtl/core/mfs_scale.sv */
module mfs_scale #(
  parameter int unsigned IN_W = 24,
  parameter int unsigned Q_W  = 33,
  parameter int unsigned P    = 1,
  parameter int unsigned B    = 0,
  parameter int unsigned D    = 1
) (
  input  logic              clk_i,
  input  mfs_pkg::mfs_adv_t adv_i,
  input  logic [IN_W-1:0]   y_i,
  output logic [Q_W-1:0]    q_o
);

  // Exact floor division by reciprocal: 2^S exceeds 2^IN_W * D
  localparam int unsigned D_W   = $clog2(D);
  localparam int unsigned P_W   = $clog2(P + 1);
  localparam int unsigned S     = IN_W + D_W + 1;
  localparam int unsigned M_W   = P_W + S - D_W + 2;
  localparam int unsigned LO_W  = M_W / 2;
  localparam int unsigned HI_W  = M_W - LO_W;
  localparam int unsigned SUM_A = IN_W + M_W + 1;
  localparam int unsigned SUM_W = (SUM_A > S + Q_W) ? SUM_A : S + Q_W;
  localparam int unsigned PLO_W = IN_W + LO_W;
  localparam int unsigned PHI_W = IN_W + HI_W;

  localparam logic [127:0] M_FULL = ((128'(P) << S) + 128'(D) - 128'd1) / 128'(D);
  localparam logic [127:0] B_FULL = ((128'(B) << S) + 128'(D) - 128'd1) / 128'(D);
  localparam logic [LO_W-1:0]  M_LO  = M_FULL[LO_W-1:0];
  localparam logic [HI_W-1:0]  M_HI  = M_FULL[M_W-1:LO_W];
  localparam logic [SUM_W-1:0] B_OFS = B_FULL[SUM_W-1:0];

  logic [PLO_W-1:0] pp_lo_d, pp_lo_q;
  logic [PHI_W-1:0] pp_hi_d, pp_hi_q;
  logic [SUM_W-1:0] sum_d;
  logic [Q_W-1:0]   q_q;

  assign pp_lo_d = PLO_W'(y_i) * PLO_W'(M_LO);
  assign pp_hi_d = PHI_W'(y_i) * PHI_W'(M_HI);
  assign sum_d   = (SUM_W'(pp_hi_q) << LO_W) + SUM_W'(pp_lo_q) + B_OFS;

  always_ff @(posedge clk_i) begin
    if (adv_i.mul) begin
      pp_lo_q <= pp_lo_d;
      pp_hi_q <= pp_hi_d;
    end
    if (adv_i.sum) begin
      q_q <= sum_d[S +: Q_W];
    end
  end

  assign q_o = q_q;

endmodule

/* rtl/core/meter_frame_hex_field_scaler_unit.sv */
// Meter frame hex field scaler.
// Input channel: one ASCII byte of a meter frame per beat (frame_byte_i), with
// frame_end_i marking the frame's last byte. Five hex fields of HEX_DIGITS
// characters sit at offsets 7, 19, 31, 43 and 55; each parse stops at the
// field's first non-hex character.
// Output channel: one beat per frame, carrying voltage, current, real power,
// power factor and reactive power as fixed-point values with 24 fractional
// bits, plus frame_short when the frame ended before the last field was in.
// Throughput: one input beat per cycle while input ready is high; bytes are
// parsed as they arrive. Pipeline: four register stages (register the raw
// fields, multiply by the reciprocal in two partial products, add and shift,
// remove the offset and clamp); out_valid_o rises once the frame's result
// has passed through all four.
// Stall: the four result stages each hold a frame; while the receiver stalls
// they fill up and input ready drops only once all four are occupied.
// Reset: the parser returns to offset zero with empty fields and all result
// stages are emptied.
module meter_frame_hex_field_scaler_unit #(
  parameter int unsigned HEX_DIGITS = mfs_pkg::HEX_DIGITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [7:0]                         frame_byte_i,
  input  logic                               frame_end_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [mfs_pkg::VOLT_W-1:0]  voltage_o,
  output logic signed [mfs_pkg::CUR_W-1:0]   current_o,
  output logic [mfs_pkg::REAL_W-1:0]         real_power_o,
  output logic signed [mfs_pkg::PF_W-1:0]    power_factor_o,
  output logic [mfs_pkg::REACT_W-1:0]        reactive_power_o,
  output logic                               frame_short_o
);

  import mfs_pkg::*;

  localparam int unsigned RAW_W    = 4 * HEX_DIGITS;
  localparam int unsigned LAST_POS = FIELD_START[FIELD_COUNT-1] + HEX_DIGITS;

  typedef struct packed {
    logic cur_zero;
    logic real_zero;
    logic react_zero;
    logic frame_short;
  } flags_t;

  // Handshake and stage advance
  logic accept, out_adv, s3_en, s2_en, s1_en;
  mfs_adv_t adv;

  // Parser state
  logic [POS_W-1:0]       pos_q;
  logic [RAW_W-1:0]       raw_q [FIELD_COUNT];
  logic [RAW_W-1:0]       raw_n [FIELD_COUNT];
  logic [FIELD_COUNT-1:0] stop_q, stop_n, win;
  logic [EXT_W-1:0]       ext   [FIELD_COUNT];
  mfs_hex_t               hex;

  // Result stages
  logic [RAW_W-1:0] y_d [FIELD_COUNT];
  logic [RAW_W-1:0] y_q [FIELD_COUNT];
  flags_t           s1_flags_d, s1_flags_q, s2_flags_q, s3_flags_q;
  logic             s1_v_q, s2_v_q, s3_v_q, out_v_q;

  logic [VOLT_Q_W-1:0]  q_volt;
  logic [CUR_Q_W-1:0]   q_cur;
  logic [REAL_Q_W-1:0]  q_real;
  logic [PF_Q_W-1:0]    q_pf;
  logic [REACT_Q_W-1:0] q_react;

  logic signed [VOLT_W-1:0] voltage_d, voltage_q;
  logic signed [CUR_W-1:0]  current_d, current_q;
  logic [REAL_W-1:0]        real_power_d, real_power_q;
  logic signed [PF_W-1:0]   power_factor_d, power_factor_q;
  logic [REACT_W-1:0]       reactive_power_d, reactive_power_q;
  logic                     frame_short_q;

  // A stage advances when it is empty or the stage after it advances
  assign out_adv    = !out_v_q || out_ready_i;
  assign s3_en      = !s3_v_q || out_adv;
  assign s2_en      = !s2_v_q || s3_en;
  assign s1_en      = !s1_v_q || s2_en;
  assign in_ready_o = s1_en;
  assign accept     = in_valid_i && s1_en;
  assign adv.mul    = s2_en;
  assign adv.sum    = s3_en;

  // Shift the byte's digit into every field whose window covers this offset
  always_comb begin
    hex = hex_decode(frame_byte_i);
    for (int k = 0; k < FIELD_COUNT; k++) begin
      win[k]    = (pos_q >= POS_W'(FIELD_START[k])) &&
                  (pos_q < POS_W'(FIELD_START[k] + HEX_DIGITS));
      raw_n[k]  = raw_q[k];
      stop_n[k] = stop_q[k];
      if (win[k] && !stop_q[k]) begin
        if (hex.ok) begin
          raw_n[k] = (raw_q[k] << 4) | RAW_W'(hex.val);
        end else begin
          stop_n[k] = 1'b1;
        end
      end
      ext[k] = EXT_W'(raw_n[k]);
    end
  end

  // Bias current, real and reactive power for non-negative divider operands
  always_comb begin
    y_d[F_VOLT]  = raw_n[F_VOLT];
    y_d[F_CUR]   = RAW_W'(ext[F_CUR] - EXT_W'(CUR_BIAS));
    y_d[F_REAL]  = RAW_W'(ext[F_REAL] - EXT_W'(REAL_BIAS));
    y_d[F_PF]    = raw_n[F_PF];
    y_d[F_REACT] = RAW_W'(ext[F_REACT] - EXT_W'(REACT_BIAS));
    s1_flags_d.cur_zero    = ext[F_CUR] <= EXT_W'(CUR_KNEE);
    s1_flags_d.real_zero   = ext[F_REAL] < EXT_W'(REAL_BIAS);
    s1_flags_d.react_zero  = ext[F_REACT] < EXT_W'(REACT_BIAS);
    s1_flags_d.frame_short = ({1'b0, pos_q} + (POS_W+1)'(1)) < (POS_W+1)'(LAST_POS);
  end

  // Parser: advance on each byte, start over after the frame's last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      stop_q <= '0;
      for (int k = 0; k < FIELD_COUNT; k++) begin
        raw_q[k] <= '0;
      end
    end else if (accept) begin
      if (frame_end_i) begin
        pos_q  <= '0;
        stop_q <= '0;
        for (int k = 0; k < FIELD_COUNT; k++) begin
          raw_q[k] <= '0;
        end
      end else begin
        if (pos_q < POS_MAX) begin
          pos_q <= pos_q + POS_W'(1);
        end
        stop_q <= stop_n;
        for (int k = 0; k < FIELD_COUNT; k++) begin
          raw_q[k] <= raw_n[k];
        end
      end
    end
  end

  // Stage occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v_q <= accept && frame_end_i;
      end
      if (s2_en) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_en) begin
        s3_v_q <= s2_v_q;
      end
      if (out_adv) begin
        out_v_q <= s3_v_q;
      end
    end
  end

  // Stage payloads: hold while the next stage is busy
  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_flags_q <= s1_flags_d;
      for (int k = 0; k < FIELD_COUNT; k++) begin
        y_q[k] <= y_d[k];
      end
    end
    if (s2_en) begin
      s2_flags_q <= s1_flags_q;
    end
    if (s3_en) begin
      s3_flags_q <= s2_flags_q;
    end
    if (out_adv) begin
      voltage_q        <= voltage_d;
      current_q        <= current_d;
      real_power_q     <= real_power_d;
      power_factor_q   <= power_factor_d;
      reactive_power_q <= reactive_power_d;
      frame_short_q    <= s3_flags_q.frame_short;
    end
  end

  mfs_scale #(
    .IN_W (RAW_W), .Q_W (VOLT_Q_W), .P (VOLT_P), .B (0), .D (VOLT_D)
  ) u_volt (
    .clk_i (clk_i), .adv_i (adv), .y_i (y_q[F_VOLT]), .q_o (q_volt)
  );

  mfs_scale #(
    .IN_W (RAW_W), .Q_W (CUR_Q_W), .P (CUR_P), .B (0), .D (CUR_D)
  ) u_cur (
    .clk_i (clk_i), .adv_i (adv), .y_i (y_q[F_CUR]), .q_o (q_cur)
  );

  mfs_scale #(
    .IN_W (RAW_W), .Q_W (REAL_Q_W), .P (REAL_P), .B (0), .D (REAL_D)
  ) u_real (
    .clk_i (clk_i), .adv_i (adv), .y_i (y_q[F_REAL]), .q_o (q_real)
  );

  mfs_scale #(
    .IN_W (RAW_W), .Q_W (PF_Q_W), .P (PF_P), .B (PF_B), .D (PF_D)
  ) u_pf (
    .clk_i (clk_i), .adv_i (adv), .y_i (y_q[F_PF]), .q_o (q_pf)
  );

  mfs_scale #(
    .IN_W (RAW_W), .Q_W (REACT_Q_W), .P (REACT_P), .B (REACT_B), .D (REACT_D)
  ) u_react (
    .clk_i (clk_i), .adv_i (adv), .y_i (y_q[F_REACT]), .q_o (q_react)
  );

  // Drop the constant term, then force zero where the raw value sits below
  // the knee (current) or the scaled value would go negative (the powers)
  always_comb begin
    voltage_d        = {1'b0, q_volt} - VOLT_OFS;
    power_factor_d   = {1'b0, q_pf} - PF_OFS;
    current_d        = s3_flags_q.cur_zero ? '0 : {1'b0, q_cur};
    real_power_d     = s3_flags_q.real_zero ? '0 : q_real;
    reactive_power_d = s3_flags_q.react_zero ? '0 : q_react;
  end

  assign out_valid_o      = out_v_q;
  assign voltage_o        = voltage_q;
  assign current_o        = current_q;
  assign real_power_o     = real_power_q;
  assign power_factor_o   = power_factor_q;
  assign reactive_power_o = reactive_power_q;
  assign frame_short_o    = frame_short_q;

  // A byte inside a frame never starts a result
  a_mid_byte_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !frame_end_i) |=> !s1_v_q)
    else $error("result stage loaded by a byte that did not end the frame");

  // The frame's last byte starts a result and rewinds the parser
  a_end_byte_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && frame_end_i) |=> (s1_v_q && pos_q == '0 && stop_q == '0))
    else $error("frame end did not load a result or rewind the parser");

  // A stalled frame in the last divider stage is kept
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_v_q && !s3_en) |=> s3_v_q)
    else $error("result lost from the quotient stage under stall");

  // Input backpressure only once every result stage is occupied
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_v_q && s2_v_q && s3_v_q && out_v_q))
    else $error("input stalled while a result stage was free");

endmodule

/* tb/meter_reading_monitor.sv */
`timescale 1ns / 1ps

module meter_reading_monitor (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [7:0]                        frame_byte_i,
  input  logic                              frame_end_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [mfs_pkg::VOLT_W-1:0]        voltage_i,
  input  logic [mfs_pkg::CUR_W-1:0]         current_i,
  input  logic [mfs_pkg::REAL_W-1:0]        real_power_i,
  input  logic [mfs_pkg::PF_W-1:0]          power_factor_i,
  input  logic [mfs_pkg::REACT_W-1:0]       reactive_power_i,
  input  logic                              frame_short_i,
  output int                                mismatch_count_o,
  output int                                readings_pending_o
);
  import mfs_pkg::*;

  localparam int unsigned DIGITS   = HEX_DIGITS_DEF;
  localparam int unsigned SPAN_END = FIELD_START[FIELD_COUNT-1] + DIGITS;
  localparam int unsigned MAX_LOGGED = 40;

  typedef struct {
    logic [VOLT_W-1:0]  voltage;
    logic [CUR_W-1:0]   current;
    logic [REAL_W-1:0]  real_power;
    logic [PF_W-1:0]    power_factor;
    logic [REACT_W-1:0] reactive_power;
    logic               frame_short;
  } reading_t;

  reading_t         expected_readings[$];
  logic [POS_W-1:0] frame_pos;
  logic [23:0]      field_raw [FIELD_COUNT];
  logic             field_halted [FIELD_COUNT];
  int               mismatch_count;

  assign mismatch_count_o = mismatch_count;

  initial mismatch_count = 0;

  // -1 for anything that is not a hex digit
  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    return -1;
  endfunction

  // floor(((raw * mul - sub) * 2^24) / den), den positive
  function automatic longint fixed_floor(input logic [23:0] raw, input longint mul,
                                         input longint sub, input longint den);
    longint num;
    longint quo;
    num = (longint'(raw) * mul - sub) * (longint'(1) << 24);
    quo = num / den;
    if (num % den != 0 && num < 0) quo -= 1;
    return quo;
  endfunction

  function automatic reading_t scale_frame(input logic [POS_W-1:0] last_pos);
    reading_t r;
    longint   v;
    v = fixed_floor(field_raw[F_VOLT], 23, 2000000, 1000000);
    r.voltage = v[VOLT_W-1:0];
    if (field_raw[F_CUR] <= CUR_KNEE) v = 0;
    else v = fixed_floor(field_raw[F_CUR], 16, 4400, 10000000);
    r.current = v[CUR_W-1:0];
    v = fixed_floor(field_raw[F_REAL], 14, 14000, 10000);
    if (v < 0) v = 0;
    r.real_power = v[REAL_W-1:0];
    v = fixed_floor(field_raw[F_PF], 48, 120000000, 1000000000);
    r.power_factor = v[PF_W-1:0];
    v = fixed_floor(field_raw[F_REACT], 18, 1600, 10000000);
    if (v < 0) v = 0;
    r.reactive_power = v[REACT_W-1:0];
    r.frame_short = (int'(last_pos) + 1 < SPAN_END);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < MAX_LOGGED)
      $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic compare_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic clear_parser();
    frame_pos = '0;
    for (int k = 0; k < FIELD_COUNT; k++) begin
      field_raw[k]    = '0;
      field_halted[k] = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int       d;
    reading_t want;
    if (!rst_ni) begin
      clear_parser();
      expected_readings.delete();
    end else begin
      // input beat: advance the parser, queue a reading on the frame's last byte
      if (in_valid_i && in_ready_i) begin
        for (int k = 0; k < FIELD_COUNT; k++) begin
          if (int'(frame_pos) >= FIELD_START[k] && int'(frame_pos) < FIELD_START[k] + DIGITS
              && !field_halted[k]) begin
            d = hex_nibble(frame_byte_i);
            if (d < 0) field_halted[k] = 1'b1;
            else field_raw[k] = {field_raw[k][19:0], d[3:0]};
          end
        end
        if (frame_end_i) begin
          expected_readings.push_back(scale_frame(frame_pos));
          clear_parser();
        end else if (frame_pos != POS_MAX) begin
          frame_pos = frame_pos + 1'b1;
        end
      end
      // output beat: compare with the oldest reading
      if (out_valid_i && out_ready_i) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("reading with no frame behind it", '0, '0);
        end else begin
          want = expected_readings.pop_front();
          compare_field("voltage", voltage_i[VOLT_W-1:0], want.voltage);
          compare_field("current", current_i[CUR_W-1:0], want.current);
          compare_field("real_power", real_power_i[REAL_W-1:0], want.real_power);
          compare_field("power_factor", power_factor_i[PF_W-1:0], want.power_factor);
          compare_field("reactive_power", reactive_power_i[REACT_W-1:0],
                        want.reactive_power);
          compare_field("frame_short", frame_short_i, want.frame_short);
        end
      end
    end
    readings_pending_o = expected_readings.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import mfs_pkg::*;

  localparam time_unit_half = 5;
  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 4;
  localparam int FRAMES_PER_PHASE = 2;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;

  typedef enum {FRAME_CLEAN, FRAME_SHORT, FRAME_LONG, FRAME_NOISE} frame_kind_e;

  logic clk_i        = 1'b0;
  logic rst_ni       = 1'b0;
  logic in_valid_i   = 1'b0;
  logic [7:0] frame_byte_i = 8'h00;
  logic frame_end_i  = 1'b0;
  logic out_ready_i  = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  logic signed [VOLT_W-1:0]  voltage_o;
  logic signed [CUR_W-1:0]   current_o;
  logic [REAL_W-1:0]         real_power_o;
  logic signed [PF_W-1:0]    power_factor_o;
  logic [REACT_W-1:0]        reactive_power_o;
  logic                      frame_short_o;

  int mismatches;
  int readings_pending;
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left    = 0;
  int cycle_count  = 0;

  // bytes of the frame about to be sent
  logic [7:0] frame_buf[$];

  always #(time_unit_half) clk_i = ~clk_i;

  meter_frame_hex_field_scaler_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .frame_byte_i     (frame_byte_i),
    .frame_end_i      (frame_end_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .voltage_o        (voltage_o),
    .current_o        (current_o),
    .real_power_o     (real_power_o),
    .power_factor_o   (power_factor_o),
    .reactive_power_o (reactive_power_o),
    .frame_short_o    (frame_short_o)
  );

  meter_reading_monitor u_monitor (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .frame_byte_i       (frame_byte_i),
    .frame_end_i        (frame_end_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .voltage_i          (voltage_o),
    .current_i          (current_o),
    .real_power_i       (real_power_o),
    .power_factor_i     (power_factor_o),
    .reactive_power_i   (reactive_power_o),
    .frame_short_i      (frame_short_o),
    .mismatch_count_o   (mismatches),
    .readings_pending_o (readings_pending)
  );

  // Watchdog: a hung handshake or a lost reading ends here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: a requested hold-off is counted down here, otherwise stall at
  // random by the current percentage.
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 10) return 8'("0") + 8'(n);
    return (lower ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
  endfunction

  // Some plain values; most weight on the zero, full-scale, knee and clamp regions.
  function automatic logic [23:0] random_raw();
    case ($urandom_range(4, 0))
      0:       return 24'($urandom);
      1:       return 24'($urandom_range(4095, 0));
      2:       return 24'($urandom_range(3600, 3400));
      3:       return $urandom_range(1, 0) ? 24'hFFFFFF : 24'h000000;
      default: return 24'($urandom_range(1100, 0));
    endcase
  endfunction

  // Fill the frame with random filler; the fields are written over it.
  task automatic open_frame(input int len);
    frame_buf.delete();
    repeat (len) frame_buf.push_back(8'($urandom_range(255, 0)));
  endtask

  task automatic put_text(input int pos, input string s);
    for (int i = 0; i < s.len(); i++)
      if (pos + i < frame_buf.size()) frame_buf[pos + i] = s[i];
  endtask

  task automatic put_field(input int k, input logic [23:0] raw, input bit lower);
    for (int i = 0; i < HEX_DIGITS_DEF; i++)
      if (FIELD_START[k] + i < frame_buf.size())
        frame_buf[FIELD_START[k] + i] = hex_char(raw[4*(HEX_DIGITS_DEF-1-i) +: 4], lower);
  endtask

  task automatic put_random_fields();
    for (int k = 0; k < FIELD_COUNT; k++)
      put_field(k, random_raw(), 1'($urandom_range(1, 0)));
  endtask

  // Offer one beat after a random gap and hold it until it is taken.
  task automatic send_beat(input logic [7:0] b, input logic last);
    while ($urandom_range(99, 0) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    frame_byte_i <= b;
    frame_end_i  <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++)
      send_beat(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  // Drop valid in the step of the last acceptance, then wait out every reading.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (readings_pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic run_directed();
    // full scale and all zero, both exactly complete frames
    open_frame(61);
    for (int k = 0; k < FIELD_COUNT; k++) put_field(k, 24'hFFFFFF, 1'b0);
    send_frame();
    open_frame(61);
    for (int k = 0; k < FIELD_COUNT; k++) put_field(k, 24'h000000, 1'b1);
    send_frame();
    // current at its knee, real and reactive power just below their clamp
    open_frame(66);
    put_field(F_VOLT, 24'h0153AD, 1'b1);
    put_field(F_CUR, 24'h000DB8, 1'b0);
    put_field(F_REAL, 24'h0003E7, 1'b1);
    put_field(F_PF, 24'h2625A0, 1'b0);
    put_field(F_REACT, 24'h000058, 1'b1);
    send_frame();
    // one step above the current, real, power factor and reactive thresholds
    open_frame(61);
    put_field(F_VOLT, 24'h000001, 1'b0);
    put_field(F_CUR, 24'h000DB9, 1'b0);
    put_field(F_REAL, 24'h0003E8, 1'b0);
    put_field(F_PF, 24'h2625A1, 1'b1);
    put_field(F_REACT, 24'h000059, 1'b0);
    send_frame();
    // prefix, sign and blank stop the parse; both letter cases accepted
    open_frame(61);
    put_text(FIELD_START[F_VOLT], "0x1A2B");
    put_text(FIELD_START[F_CUR], "-12345");
    put_text(FIELD_START[F_REAL], "12 345");
    put_text(FIELD_START[F_PF], "abcdef");
    put_text(FIELD_START[F_REACT], "ABCDEF");
    send_frame();
    // characters just outside each digit range
    open_frame(61);
    put_text(FIELD_START[F_VOLT], "9:1234");
    put_text(FIELD_START[F_CUR], "/11111");
    put_text(FIELD_START[F_REAL], "F@1234");
    put_text(FIELD_START[F_PF], "fG1234");
    put_text(FIELD_START[F_REACT], "ag1234");
    frame_buf[FIELD_START[F_VOLT] + 1] = 8'h60;
    send_frame();
    // one byte short of complete, with the last field cut mid-way
    open_frame(60);
    put_random_fields();
    send_frame();
    // a frame of one byte
    open_frame(1);
    frame_buf[0] = "F";
    send_frame();
    // past the saturation of the byte offset
    open_frame(140);
    put_random_fields();
    send_frame();
  endtask

  task automatic random_frame();
    frame_kind_e kind;
    int          roll;
    int          len;
    roll = $urandom_range(99, 0);
    if (roll < 70)      kind = FRAME_CLEAN;
    else if (roll < 85) kind = FRAME_SHORT;
    else if (roll < 92) kind = FRAME_LONG;
    else                kind = FRAME_NOISE;
    case (kind)
      FRAME_CLEAN: len = 61 + $urandom_range(8, 0);
      FRAME_SHORT: len = $urandom_range(60, 1);
      FRAME_LONG:  len = $urandom_range(150, 100);
      default:     len = 61 + $urandom_range(8, 0);
    endcase
    open_frame(len);
    if (kind != FRAME_NOISE) begin
      put_random_fields();
      // now and then break a field with a stray character
      for (int k = 0; k < FIELD_COUNT; k++)
        if ($urandom_range(6, 0) == 0)
          put_text(FIELD_START[k] + $urandom_range(HEX_DIGITS_DEF - 1, 0),
                   $urandom_range(1, 0) ? " " : "-");
    end
    send_frame();
  endtask

  initial begin
    int idle_by_phase  [PHASES];
    int stall_by_phase [PHASES];
    idle_by_phase  = '{0, 74, 0, 22};
    stall_by_phase = '{0, 0, 74, 22};

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    drain();

    for (int p = 0; p < PHASES; p++) begin
      idle_pct  = idle_by_phase[p];
      stall_pct = stall_by_phase[p];
      if (p == 0) begin
        // hold the receiver off while single-byte frames pile up behind it
        hold_request = HOLD_CYCLES;
        repeat (10) begin
          open_frame(1);
          frame_buf[0] = 8'($urandom_range(255, 0));
          send_frame();
        end
        drain();
      end
      repeat (FRAMES_PER_PHASE) random_frame();
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && readings_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
